### hdl/tdeq_pkg.sv
// tdeq_pkg: operation and result codes, store entry and result types
// for the tick deadline event queue
// depends on nothing
package tdeq_pkg;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_INSERTED    = 3'd0,
		KIND_FULL        = 3'd1,
		KIND_FIRED       = 3'd2,
		KIND_NOTHING_DUE = 3'd3,
		KIND_CANCELLED   = 3'd4,
		KIND_UNUSED      = 3'd5,
		KIND_CLEARED     = 3'd6
	} kind_t;

	// most fired beats one advance may return
	localparam logic [6:0] MAX_FIRED = 7'd64;
	// clear count saturates here
	localparam logic [6:0] COUNT_MAX = 7'd127;

	typedef struct packed {
		logic        used;
		logic        live;
		logic [63:0] due;
		logic [31:0] stamp;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  slot;
		logic [15:0] tag;
		logic [6:0]  count;
		logic        last;
	} result_t;

endpackage

### hdl/tick_deadline_event_queue.sv
// tick_deadline_event_queue: bounded timer event store with a 64-bit tick counter
// one entry memory scanned by a single compare unit under a small sequencer
// depends on tdeq_pkg
//
//  channel | direction | beat fields                            | handshake
//  --------+-----------+----------------------------------------+--------------------
//  in      | to block  | operation, delay, tag, handle          | in_valid / in_stall
//  out     | from block| kind, slot, fired_tag, count, last     | out_valid / out_stall
//
// the entry memory has a single read port, read one entry a cycle by the scanning states;
// an advance rescans the whole store once for each due event that it removes
// after reset a clearing pass writes every entry unused, with in_stall high
// in_stall is low only while the sequencer is idle; a result waits in the output
// register while out_stall is high, and the sequencer holds until that register frees
module tick_deadline_event_queue import tdeq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [23:0] delay,
	input  logic [15:0] tag,
	input  logic [5:0]  handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [5:0]  slot,
	output logic [15:0] fired_tag,
	output logic [6:0]  count,
	output logic        last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] SCAN_END = CW'(CAPACITY);

	// sequencer states
	typedef enum logic [8:0] {
		ST_INIT       = 9'b000000001,
		ST_IDLE       = 9'b000000010,
		ST_FIND       = 9'b000000100,
		ST_CANCEL     = 9'b000001000,
		ST_CANCEL_CHK = 9'b000010000,
		ST_CLEAR      = 9'b000100000,
		ST_SCAN       = 9'b001000000,
		ST_PICK       = 9'b010000000,
		ST_EMIT       = 9'b100000000
	} state_t;

	state_t state_q;

	// captured input beat
	logic [23:0] delay_q;
	logic [15:0] tag_q;
	logic [5:0]  handle_q;

	// global state
	logic [63:0] now_q;
	logic [31:0] next_stamp_q;

	// scan address counter and first read stage
	logic [CW-1:0] scan_idx_q;
	logic          rd_v_s1;
	logic [AW-1:0] idx_s1;
	entry_t        rdata_s1;

	// best due candidate of the current pass
	logic          best_v_q;
	logic [AW-1:0] best_idx_q;
	logic [63:0]   best_due_q;
	logic [31:0]   best_age_q;
	logic          best_live_q;
	logic [15:0]   best_tag_q;

	logic [6:0] fired_n_q;    // fired beats produced by this advance
	logic [6:0] clr_cnt_q;    // used slots seen by this clear
	result_t    res_q;        // result being built, or fired beat held back
	result_t    out_q;
	logic       out_valid_q;

	// entry memory
	entry_t        mem [CAPACITY];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;

	logic          issue;
	logic          out_free;
	logic          out_load;
	result_t       out_next;
	logic [AW-1:0] handle_addr;
	logic [31:0]   cand_age;
	logic          cand_due;
	logic          take;
	logic          pick_done;
	logic          need_push;
	logic [6:0]    clr_cnt_next;
	entry_t        new_entry;
	entry_t        cancel_entry;

	// whole result beat in one go
	function automatic result_t make_res(kind_t k, logic [5:0] s, logic [15:0] t,
			logic [6:0] c, logic l);
		result_t r;
		r.kind  = k;
		r.slot  = s;
		r.tag   = t;
		r.count = c;
		r.last  = l;
		return r;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign slot      = out_q.slot;
	assign fired_tag = out_q.tag;
	assign count     = out_q.count;
	assign last      = out_q.last;

	// output register takes a beat when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	assign handle_addr = AW'(handle_q);

	// reads walk the store one entry a cycle in the scanning states
	assign issue = ((state_q == ST_FIND) || (state_q == ST_CLEAR) || (state_q == ST_SCAN))
		&& (scan_idx_q != SCAN_END);
	assign mem_raddr = (state_q == ST_CANCEL) ? handle_addr : scan_idx_q[AW-1:0];

	// shared compare unit: due test and firing order against the best so far
	assign cand_age = next_stamp_q - rdata_s1.stamp;
	assign cand_due = rdata_s1.used && (rdata_s1.due <= now_q);
	assign take     = rd_v_s1 && cand_due && (!best_v_q
		|| (rdata_s1.due < best_due_q)
		|| ((rdata_s1.due == best_due_q) && (cand_age > best_age_q)));

	// end of advance: nothing due, or a live event beyond the beat limit
	assign pick_done = !best_v_q || (best_live_q && (fired_n_q == MAX_FIRED));
	// a new live event pushes the held beat out first
	assign need_push = best_live_q && (fired_n_q != 7'd0);

	assign clr_cnt_next = (rdata_s1.used && (clr_cnt_q != COUNT_MAX)) ?
		clr_cnt_q + 7'd1 : clr_cnt_q;

	always_comb begin
		new_entry       = '0;
		new_entry.used  = 1'b1;
		new_entry.live  = 1'b1;
		new_entry.due   = now_q + 64'(delay_q);
		new_entry.stamp = next_stamp_q;
		new_entry.tag   = tag_q;
		cancel_entry      = rdata_s1;
		cancel_entry.live = 1'b0;
	end

	// memory write port and output register load
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		out_load  = 1'b0;
		out_next  = res_q;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = scan_idx_q[AW-1:0];
			end
			ST_FIND: begin
				if (rd_v_s1 && !rdata_s1.used) begin
					mem_we    = 1'b1;
					mem_wdata = new_entry;
				end
			end
			ST_CANCEL_CHK: begin
				if (rdata_s1.used) begin
					mem_we    = 1'b1;
					mem_waddr = handle_addr;
					mem_wdata = cancel_entry;
				end
			end
			ST_CLEAR: begin
				mem_we = rd_v_s1;
			end
			ST_PICK: begin
				if (!pick_done && (!need_push || out_free)) begin
					mem_we    = 1'b1;
					mem_waddr = best_idx_q;
					out_load  = need_push;
				end
			end
			ST_EMIT: begin
				out_load = out_free;
			end
			ST_IDLE, ST_CANCEL, ST_SCAN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			delay_q      <= '0;
			tag_q        <= '0;
			handle_q     <= '0;
			now_q        <= '0;
			next_stamp_q <= '0;
			scan_idx_q   <= '0;
			rd_v_s1      <= 1'b0;
			idx_s1       <= '0;
			best_v_q     <= 1'b0;
			best_idx_q   <= '0;
			best_due_q   <= '0;
			best_age_q   <= '0;
			best_live_q  <= 1'b0;
			best_tag_q   <= '0;
			fired_n_q    <= '0;
			clr_cnt_q    <= '0;
			res_q        <= '0;
		end else begin
			rd_v_s1 <= issue;
			idx_s1  <= scan_idx_q[AW-1:0];
			if (issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			unique case (state_q)
				ST_INIT: begin
					if (scan_idx_q[AW-1:0] == LAST_IDX) begin
						scan_idx_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						delay_q    <= delay;
						tag_q      <= tag;
						handle_q   <= handle;
						scan_idx_q <= '0;
						unique case (op_t'(operation))
							OP_INSERT: begin
								state_q <= ST_FIND;
							end
							OP_CANCEL: begin
								if (32'(handle) < 32'(CAPACITY)) begin
									state_q <= ST_CANCEL;
								end else begin
									res_q   <= make_res(KIND_UNUSED, handle, '0, '0, 1'b1);
									state_q <= ST_EMIT;
								end
							end
							OP_ADVANCE: begin
								fired_n_q <= '0;
								best_v_q  <= 1'b0;
								state_q   <= ST_SCAN;
							end
							OP_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FIND: begin
					if (rd_v_s1) begin
						if (!rdata_s1.used) begin
							next_stamp_q <= next_stamp_q + 32'd1;
							res_q   <= make_res(KIND_INSERTED, 6'(idx_s1), tag_q, '0, 1'b1);
							state_q <= ST_EMIT;
						end else if (idx_s1 == LAST_IDX) begin
							res_q   <= make_res(KIND_FULL, '0, '0, '0, 1'b1);
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CANCEL: begin
					state_q <= ST_CANCEL_CHK;
				end
				ST_CANCEL_CHK: begin
					res_q   <= make_res(rdata_s1.used ? KIND_CANCELLED : KIND_UNUSED,
						handle_q, '0, '0, 1'b1);
					state_q <= ST_EMIT;
				end
				ST_CLEAR: begin
					if (rd_v_s1) begin
						clr_cnt_q <= clr_cnt_next;
						if (idx_s1 == LAST_IDX) begin
							res_q   <= make_res(KIND_CLEARED, '0, '0, clr_cnt_next, 1'b1);
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					if (take) begin
						best_v_q    <= 1'b1;
						best_idx_q  <= idx_s1;
						best_due_q  <= rdata_s1.due;
						best_age_q  <= cand_age;
						best_live_q <= rdata_s1.live;
						best_tag_q  <= rdata_s1.tag;
					end
					if (rd_v_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (pick_done) begin
						now_q <= now_q + 64'd1;
						if (fired_n_q == 7'd0) begin
							res_q <= make_res(KIND_NOTHING_DUE, '0, '0, '0, 1'b1);
						end else begin
							res_q.last <= 1'b1;
						end
						state_q <= ST_EMIT;
					end else if (!need_push || out_free) begin
						// remove the picked event, hold its beat if live, rescan
						if (best_live_q) begin
							res_q     <= make_res(KIND_FIRED, 6'(best_idx_q), best_tag_q,
								'0, 1'b0);
							fired_n_q <= fired_n_q + 7'd1;
						end
						best_v_q   <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_q       <= out_next;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for tick_deadline_event_queue, with directed and random operations,
// a clocked driver and monitor, and an in-bench event store that predicts every result beat
// depends on tdeq_pkg and the tick_deadline_event_queue rtl
module tb;
	import tdeq_pkg::*;

	localparam int SLOTS = 64;
	localparam int RANDOM_ITEMS = 370;
	// one more than the longest receiver stall and sender gap that pick_gap can return
	localparam int LONGEST_GAP = 61;

	typedef struct packed {
		op_t         op;
		logic [23:0] dly;
		logic [15:0] tg;
		logic [5:0]  hdl;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [23:0] delay = '0;
	logic [15:0] tag = '0;
	logic [5:0]  handle = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [5:0]  slot;
	logic [15:0] fired_tag;
	logic [6:0]  count;
	logic        last;

	// operations waiting for the driver, and results waiting for the monitor
	req_t    stim_q[$];
	result_t exp_q[$];
	req_t    cur;

	// predicted contents of the event store
	logic [63:0] now_tick;
	logic [31:0] stamp_next;
	logic [63:0] due_mem[SLOTS];
	logic [15:0] tag_mem[SLOTS];
	logic [31:0] stamp_mem[SLOTS];
	bit          used_mem[SLOTS];
	bit          live_mem[SLOTS];

	int     err_cnt = 0;
	int     beats_in = 0;
	int     total_items = 0;
	longint cycles = 0;
	longint cycle_limit = 64'h7FFF_FFFF_FFFF_FFFF;
	bit     in_took = 1'b0;
	int     send_gap = 0;
	int     send_calm = 0;
	int     stall_left = 0;
	int     recv_calm = 0;

	tick_deadline_event_queue #(.CAPACITY(SLOTS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.delay     (delay),
		.tag       (tag),
		.handle    (handle),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.slot      (slot),
		.fired_tag (fired_tag),
		.count     (count),
		.last      (last)
	);

	always #5 clk = ~clk;

	// one line per mismatch, and a running error count
	task automatic report_err(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic void push_result(kind_t k, logic [5:0] s, logic [15:0] t,
			logic [6:0] c, logic l);
		result_t r;
		r.kind  = k;
		r.slot  = s;
		r.tag   = t;
		r.count = c;
		r.last  = l;
		exp_q.insert(exp_q.size(), r);
	endfunction

	// firing order: earlier deadline first, then the older arrival
	function automatic bit fires_first(int a, int b);
		logic [31:0] age_a;
		logic [31:0] age_b;
		age_a = stamp_next - stamp_mem[a];
		age_b = stamp_next - stamp_mem[b];
		if (due_mem[a] != due_mem[b])
			return due_mem[a] < due_mem[b];
		return age_a > age_b;
	endfunction

	// apply one accepted operation to the predicted store and queue up its result beats
	function automatic void step_event_store(op_t op, logic [23:0] dly, logic [15:0] tg,
			logic [5:0] hdl);
		int         free_ix;
		int         best;
		int         fired;
		int         i;
		logic [6:0] held;
		bit         scanning;
		result_t    tail;
		case (op)
		OP_INSERT: begin
			// lowest free slot becomes the handle
			free_ix = -1;
			for (i = SLOTS - 1; i >= 0; i--)
				if (!used_mem[i])
					free_ix = i;
			if (free_ix < 0) begin
				push_result(KIND_FULL, '0, '0, '0, 1'b1);
			end else begin
				due_mem[free_ix]   = now_tick + 64'(dly);
				tag_mem[free_ix]   = tg;
				stamp_mem[free_ix] = stamp_next;
				stamp_next         = stamp_next + 32'd1;
				used_mem[free_ix]  = 1'b1;
				live_mem[free_ix]  = 1'b1;
				push_result(KIND_INSERTED, free_ix[5:0], tg, '0, 1'b1);
			end
		end
		OP_CANCEL: begin
			// a second cancel of a pending event still reports cancelled
			if (hdl < SLOTS && used_mem[hdl]) begin
				live_mem[hdl] = 1'b0;
				push_result(KIND_CANCELLED, hdl, '0, '0, 1'b1);
			end else begin
				push_result(KIND_UNUSED, hdl, '0, '0, 1'b1);
			end
		end
		OP_ADVANCE: begin
			fired    = 0;
			scanning = 1'b1;
			while (scanning) begin
				best = -1;
				for (i = 0; i < SLOTS; i++)
					if (used_mem[i] && due_mem[i] <= now_tick &&
							(best < 0 || fires_first(i, best)))
						best = i;
				if (best < 0) begin
					scanning = 1'b0;
				end else if (live_mem[best] && fired >= MAX_FIRED) begin
					// leftovers stay due for the next advance
					scanning = 1'b0;
				end else begin
					// cancelled events leave silently
					if (live_mem[best]) begin
						push_result(KIND_FIRED, best[5:0], tag_mem[best], '0, 1'b0);
						fired++;
					end
					used_mem[best] = 1'b0;
					live_mem[best] = 1'b0;
				end
			end
			now_tick = now_tick + 64'd1;
			if (fired == 0) begin
				push_result(KIND_NOTHING_DUE, '0, '0, '0, 1'b1);
			end else begin
				tail      = exp_q.pop_back();
				tail.last = 1'b1;
				exp_q.insert(exp_q.size(), tail);
			end
		end
		OP_CLEAR: begin
			held = '0;
			for (i = 0; i < SLOTS; i++) begin
				if (used_mem[i] && held != COUNT_MAX)
					held++;
				used_mem[i] = 1'b0;
				live_mem[i] = 1'b0;
			end
			push_result(KIND_CLEARED, '0, '0, held, 1'b1);
		end
		endcase
	endfunction

	// compare one result beat against the oldest prediction
	task automatic check_result();
		result_t want;
		if (exp_q.size() == 0) begin
			report_err($sformatf("result with none expected: kind %0d slot %0d tag %h",
				kind, slot, fired_tag));
		end else begin
			want = exp_q.pop_front();
			if (kind !== want.kind)
				report_err($sformatf("kind got %0d want %0d", kind, want.kind));
			if (slot !== want.slot)
				report_err($sformatf("slot got %0d want %0d", slot, want.slot));
			if (fired_tag !== want.tag)
				report_err($sformatf("fired_tag got %h want %h", fired_tag, want.tag));
			if (count !== want.count)
				report_err($sformatf("count got %0d want %0d", count, want.count));
			if (last !== want.last)
				report_err($sformatf("last got %b want %b (kind %0d)", last, want.last,
					want.kind));
		end
	endtask

	// gap lengths: mostly none or short, a few long, with occasional calm stretches
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, LONGEST_GAP - 1);
	endfunction

	function automatic logic [23:0] rand_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			return 24'($urandom_range(0, 6));
		if (r < 88)
			return 24'($urandom_range(7, 300));
		return 24'($urandom());
	endfunction

	function automatic logic [5:0] rand_handle();
		// low slots are the ones most likely in use
		if ($urandom_range(0, 9) < 7)
			return 6'($urandom_range(0, 15));
		return 6'($urandom_range(0, 63));
	endfunction

	task automatic add_req(op_t op, logic [23:0] dly, logic [15:0] tg, logic [5:0] hdl);
		req_t q;
		q.op  = op;
		q.dly = dly;
		q.tg  = tg;
		q.hdl = hdl;
		stim_q.insert(stim_q.size(), q);
	endtask

	// driver: moves on only once the current beat has been taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					cur = stim_q.pop_front();
					operation <= cur.op;
					delay     <= cur.dly;
					tag       <= cur.tg;
					handle    <= cur.hdl;
					in_valid  <= 1'b1;
					send_gap  = pick_gap(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure, independent of out_valid
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(recv_calm);
		end
	end

	// monitor: predict on each accepted input beat, check each accepted output beat
	always @(posedge clk) begin
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				step_event_store(op_t'(operation), delay, tag, handle);
				beats_in++;
			end
			if (out_valid && !out_stall)
				check_result();
		end else begin
			in_took <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= cycle_limit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				exp_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int base;
		int n;
		int k;
		int pick;
		now_tick   = '0;
		stamp_next = '0;
		for (k = 0; k < SLOTS; k++) begin
			due_mem[k]   = '0;
			tag_mem[k]   = '0;
			stamp_mem[k] = '0;
			used_mem[k]  = 1'b0;
			live_mem[k]  = 1'b0;
		end

		// directed: empty store, unused slots, extreme fields, double cancel,
		// a silently dropped cancelled event and tie order by arrival
		add_req(OP_ADVANCE, '0, '0, '0);
		add_req(OP_CANCEL, '0, '0, 6'd0);
		add_req(OP_CANCEL, '0, '0, 6'd63);
		add_req(OP_INSERT, 24'd0, 16'hFFFF, '0);
		add_req(OP_INSERT, 24'hFFFFFF, 16'h0000, 6'd63);
		add_req(OP_INSERT, 24'd1, 16'h1234, '0);
		add_req(OP_INSERT, 24'd0, 16'hA5A5, '0);
		add_req(OP_CANCEL, 24'hFFFFFF, 16'hFFFF, 6'd1);
		add_req(OP_CANCEL, '0, '0, 6'd1);
		add_req(OP_INSERT, 24'd0, 16'h5A5A, '0);
		add_req(OP_CANCEL, '0, '0, 6'd4);
		// slots 0 and 3 fire in arrival order, slot 4 is dropped
		add_req(OP_ADVANCE, '0, '0, '0);
		add_req(OP_ADVANCE, '0, '0, '0);
		add_req(OP_CANCEL, '0, '0, 6'd0);
		// a later arrival lands in a lower slot with the same deadline
		add_req(OP_INSERT, 24'd0, 16'h0F0F, '0);
		add_req(OP_INSERT, 24'd5, 16'hF0F0, '0);
		add_req(OP_ADVANCE, '0, '0, '0);
		add_req(OP_INSERT, 24'd4, 16'h3C3C, '0);
		for (k = 0; k < 5; k++)
			add_req(OP_ADVANCE, '0, '0, '0);
		add_req(OP_CLEAR, '0, '0, '0);
		base = stim_q.size();

		// fill past capacity with everything due now, then fire all of them at once
		for (k = 0; k < SLOTS + 2; k++)
			add_req(OP_INSERT, 24'd0, 16'($urandom()), '0);
		add_req(OP_ADVANCE, '0, '0, '0);
		add_req(OP_ADVANCE, '0, '0, '0);
		// fill again and clear a full store
		for (k = 0; k < SLOTS + 1; k++)
			add_req(OP_INSERT, rand_delay(), 16'($urandom()), '0);
		add_req(OP_CLEAR, '0, '0, '0);

		// random sequences, mostly inserts followed by advances and cancels
		while (stim_q.size() < base + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					add_req(OP_INSERT, rand_delay(), 16'($urandom()), 6'($urandom()));
			end else if (pick < 66) begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					add_req(OP_ADVANCE, 24'($urandom()), 16'($urandom()),
						6'($urandom()));
			end else if (pick < 88) begin
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++)
					add_req(OP_CANCEL, 24'($urandom()), 16'($urandom()), rand_handle());
			end else if (pick < 94) begin
				add_req(OP_CLEAR, 24'($urandom()), 16'($urandom()), 6'($urandom()));
			end else if (pick < 96) begin
				// near-full burst with short deadlines, then drain it
				for (k = 0; k < SLOTS; k++)
					add_req(OP_INSERT, 24'($urandom_range(0, 3)), 16'($urandom()), '0);
				for (k = 0; k < 4; k++)
					add_req(OP_ADVANCE, '0, '0, '0);
			end else begin
				// noise: any operation with any field values
				add_req(op_t'(2'($urandom_range(0, 3))), 24'($urandom()),
					16'($urandom()), 6'($urandom()));
			end
		end
		total_items = stim_q.size();
		// worst case per item: largest advance, every beat stalled, longest sender gap
		cycle_limit = 1000 + SLOTS + 4 * longint'(total_items) *
			((SLOTS + 1) * (SLOTS + 2) + SLOTS * LONGEST_GAP + LONGEST_GAP);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_in != total_items)
			@(negedge clk);
		while (exp_q.size() != 0)
			@(negedge clk);
		// let any stray beat show itself
		repeat (300) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
